/* hw/rtl/twdict_pkg.sv */
`timescale 1ns / 1ps

package twdict_pkg;

    localparam int NODE_COUNT  = 4096;
    localparam int ALPHA_SIZE  = 26;
    localparam int NODE_W      = $clog2(NODE_COUNT);
    localparam int FREE_W      = NODE_W + 1;
    localparam int ID_W        = 16;
    localparam int LETTER_W    = 5;
    localparam int ACT_W       = 2;
    localparam int S_FIELD_W   = LETTER_W + ID_W;
    localparam int S_DATA_W    = ((S_FIELD_W + 7) / 8) * 8;
    localparam int M_DATA_W    = 2 * ID_W;

    localparam logic [ACT_W-1:0] ACT_INS_AUTO  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_INS_GIVEN = 2'd1;
    localparam logic [ACT_W-1:0] ACT_LOOKUP    = 2'd2;

    // One trie node: its id, its word-end mark and one link per letter (0 = none)
    typedef struct packed {
        logic [ID_W-1:0]                    id;
        logic                               word_end;
        logic [ALPHA_SIZE-1:0][NODE_W-1:0]  kids;
    } t_row;

endpackage

/* hw/rtl/trie_word_id_dictionary_unit.sv */
`timescale 1ns / 1ps
// A letter is accepted only in the idle state: its node row is read into a register, then the
// walk step writes back any new link; no new letter is taken until it returns to idle. A last
// letter that ends on a node goes on to a finish state that fills the output register; one that
// fails or ends at the root reports from the walk step. Results are held in an output register until taken.
// Reset (i_rst_n low, synchronous) clears control state, then a clearing pass writes all
// 4096 node rows, one per cycle, before the first request is accepted.
module trie_word_id_dictionary_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [twdict_pkg::ID_W-1:0]        i_cfg_wr_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // letter [4:0], given_id [20:5], zero [23:21]
    input  logic [twdict_pkg::S_DATA_W-1:0]    s_axis_tdata,
    // last_letter
    input  logic                               s_axis_tlast,
    // action [1:0]
    input  logic [twdict_pkg::ACT_W-1:0]       s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // word_id [15:0], total_words [31:16]
    output logic [twdict_pkg::M_DATA_W-1:0]    m_axis_tdata,
    // pool_full [0]
    output logic [0:0]                         m_axis_tuser
);
    import twdict_pkg::*;

    localparam logic [1:0] ST_CLR  = 2'd0;
    localparam logic [1:0] ST_IDLE = 2'd1;
    localparam logic [1:0] ST_PROC = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    localparam logic [NODE_W-1:0] CLR_LAST = NODE_W'(NODE_COUNT - 1);

    t_row                   mem [NODE_COUNT];
    t_row                   r_rd;

    logic [1:0]             r_state, n_state;
    logic [NODE_W-1:0]      r_clr, n_clr;
    logic [NODE_W-1:0]      r_cur, n_cur;
    logic                   r_fail, n_fail;
    logic [FREE_W-1:0]      r_nfree, n_nfree;
    logic [ID_W-1:0]        r_auto, n_auto;
    logic [ID_W-1:0]        r_base, n_base;

    logic [ACT_W-1:0]       r_act, n_act;
    logic [LETTER_W-1:0]    r_letter, n_letter;
    logic                   r_last, n_last;
    logic [ID_W-1:0]        r_given, n_given;

    logic                   r_ovalid, n_ovalid;
    logic [ID_W-1:0]        r_oid, n_oid;
    logic [ID_W-1:0]        r_otot, n_otot;
    logic                   r_ofull, n_ofull;

    logic                   mem_we, mem_re;
    logic [NODE_W-1:0]      mem_waddr, mem_raddr;
    t_row                   mem_wdata;

    logic                   accept, out_free, is_ins, step;
    logic [NODE_W-1:0]      child;
    logic [NODE_W-1:0]      w_cur;
    logic                   w_fail, w_alloc;
    logic [ID_W:0]          sum_now, sum_inc;
    logic [ID_W-1:0]        tot_now, tot_inc, auto_inc;
    t_row                   alloc_row, fin_row;
    logic [ID_W-1:0]        fin_id, fin_tot;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {r_otot, r_oid};
    assign m_axis_tuser  = r_ofull;

    always_comb begin
        out_free = !r_ovalid || m_axis_tready;
        is_ins   = (r_act == ACT_INS_AUTO) || (r_act == ACT_INS_GIVEN);
        step     = !r_fail && (int'(r_letter) < ALPHA_SIZE);
        child    = r_rd.kids[r_letter];

        // saturating totals before and after an automatic id is taken
        auto_inc = (r_auto != '1) ? r_auto + ID_W'(1) : r_auto;
        sum_now  = {1'b0, r_base} + {1'b0, r_auto};
        sum_inc  = {1'b0, r_base} + {1'b0, auto_inc};
        tot_now  = sum_now[ID_W] ? '1 : sum_now[ID_W-1:0];
        tot_inc  = sum_inc[ID_W] ? '1 : sum_inc[ID_W-1:0];

        // one step of the walk
        w_cur   = r_cur;
        w_fail  = r_fail;
        w_alloc = 1'b0;
        if (step) begin
            if (child != '0) begin
                w_cur = child;
            end else if (!is_ins) begin
                w_fail = 1'b1;
            end else if (r_nfree < FREE_W'(NODE_COUNT)) begin
                w_alloc = 1'b1;
                w_cur   = r_nfree[NODE_W-1:0];
            end else begin
                w_fail = 1'b1;
            end
        end
        alloc_row = r_rd;
        alloc_row.kids[r_letter] = r_nfree[NODE_W-1:0];

        // word-end update of the final node
        fin_row = r_rd;
        fin_tot = tot_now;
        if (is_ins) begin
            fin_row.word_end = 1'b1;
            if (r_rd.id == '0) begin
                if (r_act == ACT_INS_AUTO) begin
                    fin_row.id = tot_inc;
                    fin_tot    = tot_inc;
                end else begin
                    fin_row.id = r_given;
                end
            end
            fin_id = fin_row.id;
        end else begin
            fin_id = r_rd.word_end ? r_rd.id : '0;
        end

        n_state  = r_state;
        n_clr    = r_clr;
        n_cur    = r_cur;
        n_fail   = r_fail;
        n_nfree  = r_nfree;
        n_auto   = r_auto;
        n_base   = i_cfg_wr_en ? i_cfg_wr_data : r_base;
        n_act    = r_act;
        n_letter = r_letter;
        n_last   = r_last;
        n_given  = r_given;
        n_ovalid = r_ovalid && !m_axis_tready;
        n_oid    = r_oid;
        n_otot   = r_otot;
        n_ofull  = r_ofull;
        mem_we    = 1'b0;
        mem_waddr = r_cur;
        mem_wdata = alloc_row;
        mem_re    = 1'b0;
        mem_raddr = r_cur;

        case (r_state)
            ST_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
                n_clr     = r_clr + NODE_W'(1);
                if (r_clr == CLR_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_act    = s_axis_tuser;
                    n_letter = s_axis_tdata[LETTER_W-1:0];
                    n_given  = s_axis_tdata[S_FIELD_W-1:LETTER_W];
                    n_last   = s_axis_tlast;
                    mem_re   = 1'b1;
                    n_state  = ST_PROC;
                end
            end
            ST_PROC: begin
                if (!r_last || (!w_fail && w_cur != '0)) begin
                    mem_we  = w_alloc;
                    n_cur   = w_cur;
                    n_fail  = w_fail;
                    n_nfree = w_alloc ? r_nfree + FREE_W'(1) : r_nfree;
                    if (r_last) begin
                        // fetch the final node's row for its word-end update or its lookup result
                        mem_re    = 1'b1;
                        mem_raddr = w_cur;
                        n_state   = ST_FIN;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end else if (out_free) begin
                    n_ovalid = 1'b1;
                    n_oid    = '0;
                    n_otot   = tot_now;
                    n_ofull  = w_fail && is_ins;
                    n_cur    = '0;
                    n_fail   = 1'b0;
                    n_state  = ST_IDLE;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    mem_we    = is_ins;
                    mem_wdata = fin_row;
                    if (is_ins && r_rd.id == '0 && r_act == ACT_INS_AUTO) begin
                        n_auto = auto_inc;
                    end
                    n_ovalid = 1'b1;
                    n_oid    = fin_id;
                    n_otot   = fin_tot;
                    n_ofull  = 1'b0;
                    n_cur    = '0;
                    n_fail   = 1'b0;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd <= mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLR;
            r_clr    <= '0;
            r_cur    <= '0;
            r_fail   <= 1'b0;
            r_nfree  <= FREE_W'(1);
            r_auto   <= '0;
            r_base   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_cur    <= n_cur;
            r_fail   <= n_fail;
            r_nfree  <= n_nfree;
            r_auto   <= n_auto;
            r_base   <= n_base;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act    <= n_act;
        r_letter <= n_letter;
        r_last   <= n_last;
        r_given  <= n_given;
        r_oid    <= n_oid;
        r_otot   <= n_otot;
        r_ofull  <= n_ofull;
    end

endmodule

/* hw/rtl/twdict_checker.sv */
`timescale 1ns / 1ps
module twdict_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic                               s_axis_tlast,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [twdict_pkg::M_DATA_W-1:0]    m_axis_tdata,
    input logic [0:0]                         m_axis_tuser
);
    import twdict_pkg::*;

    // a held result must not change under the consumer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // no request is accepted on consecutive cycles
    a_two_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted on consecutive cycles");

    // an abandoned insert reports no id
    a_full_no_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[ID_W-1:0] == '0)
        else $error("pool full result with a non-zero id");

    // only a last letter yields a result
    a_no_mid_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tlast && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result from a letter that was not last");

    // reset empties the output and starts the clearing pass
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && !s_axis_tready)
        else $error("block not quiet after reset");

endmodule

bind trie_word_id_dictionary_unit twdict_checker u_twdict_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
